/* hdl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants for the set-associative cache tag store with
// timestamp LRU replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

  // default sizing of the tag store
  localparam int unsigned MAX_SET_BITS_DEF = 6;
  localparam int unsigned MAX_WAYS_DEF     = 8;
  localparam int unsigned STAMP_WIDTH_DEF  = 48;

  // field widths
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned OPC_W   = 2;
  localparam int unsigned OC_W    = 2;
  localparam int unsigned SB_W    = 3;
  localparam int unsigned BB_W    = 6;
  localparam int unsigned WAYS_W  = 4;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // opcodes
  localparam logic [OPC_W-1:0] OP_FETCH  = 2'd0;
  localparam logic [OPC_W-1:0] OP_MODIFY = 2'd3;

  // access outcomes
  localparam logic [OC_W-1:0] OC_HIT   = 2'd0;
  localparam logic [OC_W-1:0] OC_FILL  = 2'd1;
  localparam logic [OC_W-1:0] OC_EVICT = 2'd2;

  // register indexes (word address)
  localparam logic [PADDR_W-3:0] REG_SET_BITS   = 2'd0;
  localparam logic [PADDR_W-3:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [PADDR_W-3:0] REG_WAYS       = 2'd2;

  localparam logic [WAYS_W-1:0] WAYS_RST = 4'd1;

  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [OC_W-1:0]  outcome;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [SB_W-1:0]   set_bits;
    logic [BB_W-1:0]   block_bits;
    logic [WAYS_W-1:0] ways_in_use;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;
    logic lookup;
    logic reread;
    logic eval;
    logic update;
    logic last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

/* hdl/set_associative_cache_lru_model_core.sv */
// ----------------------------------------------------------------------------
// set_associative_cache_lru_model_core
// Each access other than a fetch reads its set's row of the tag store,
// compares tags, picks a victim and writes the row back with one result; a
// modify does this twice for two results, a fetch gives none. A new access
// waits until the last row write, which stalls while a result is unread.
// Reset: the store is cleared by a pass over all 2^MAX_SET_BITS rows (64 at
// the default size) during which no transaction is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_associative_cache_lru_model_core import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = MAX_WAYS_DEF,
  parameter int unsigned STAMP_WIDTH  = STAMP_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sacl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sacl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sacl_dpath #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .STAMP_WIDTH  (STAMP_WIDTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_address_i (in_data_i.address),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

/* hdl/sacl_regs.sv */
// ----------------------------------------------------------------------------
// sacl_regs
// APB configuration registers: set index bits, block offset bits and
// associativity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_regs import sacl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  logic [SB_W-1:0]    set_bits_q;
  logic [BB_W-1:0]    block_bits_q;
  logic [WAYS_W-1:0]  ways_q;
  logic               wr_en;
  logic [PADDR_W-3:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= '0;
      block_bits_q <= '0;
      ways_q       <= WAYS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SET_BITS:   set_bits_q   <= pwdata[SB_W-1:0];
        REG_BLOCK_BITS: block_bits_q <= pwdata[BB_W-1:0];
        REG_WAYS:       ways_q       <= pwdata[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_SET_BITS:   prdata = PDATA_W'(set_bits_q);
      REG_BLOCK_BITS: prdata = PDATA_W'(block_bits_q);
      REG_WAYS:       prdata = PDATA_W'(ways_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = '{set_bits: set_bits_q, block_bits: block_bits_q, ways_in_use: ways_q};

endmodule

/* hdl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: clearing pass after reset, then lookup, compare and update
// steps for each access other than a fetch, which only looks up; a modify runs the access sequence twice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_ctrl import sacl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [OPC_W-1:0] in_opcode_i,
  output logic             in_ready_o,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       second_q, second_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    second_d   = second_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.lookup = 1'b1;
          if (in_opcode_i != OP_FETCH) begin
            second_d = (in_opcode_i == OP_MODIFY);
            state_d  = ST_EVAL;
          end
        end
      end
      ST_READ: begin
        cmd_o.reread = 1'b1;
        state_d      = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ST_UPD;
      end
      ST_UPD: begin
        if (sts_i.out_free) begin
          cmd_o.update = 1'b1;
          cmd_o.last   = ~second_q;
          if (second_q) begin
            second_d = 1'b0;
            state_d  = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

/* hdl/sacl_dpath.sv */
// ----------------------------------------------------------------------------
// sacl_dpath
// Tag store memory (one row per set, all ways side by side), address split,
// parallel tag compare, LRU victim pick, stamp clock, totals and the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_dpath import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int unsigned MAX_WAYS     = MAX_WAYS_DEF,
  parameter int unsigned STAMP_WIDTH  = STAMP_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic [ADDR_W-1:0] in_address_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_t              out_data_o
);

  localparam int unsigned ROWS   = 1 << MAX_SET_BITS;
  localparam int unsigned SET_IW = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_IW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  // tag store rows
  logic [MAX_WAYS-1:0]                   mem_valid [ROWS];
  logic [MAX_WAYS-1:0][ADDR_W-1:0]       mem_tag   [ROWS];
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  mem_stamp [ROWS];

  logic [MAX_WAYS-1:0]                   rd_valid_q;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]       rd_tag_q;
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  rd_stamp_q;

  logic [MAX_WAYS-1:0]                   wr_valid;
  logic [MAX_WAYS-1:0][ADDR_W-1:0]       wr_tag;
  logic [MAX_WAYS-1:0][STAMP_WIDTH-1:0]  wr_stamp;

  logic [SET_IW-1:0] clr_cnt_q;
  logic [SET_IW-1:0] set_q, set_lk, rd_addr;
  logic [ADDR_W-1:0] tag_q, tag_lk;
  logic [ADDR_W-1:0] blk_shift, set_mask, set_full;
  logic [SB_W:0]     sb_eff;
  logic [6:0]        tag_amt;
  logic              rd_en;

  logic [WAYS_W:0]     ways_raw, ways_eff;
  logic [MAX_WAYS-1:0] in_use, match, is_min;
  logic                hit_any;
  logic [WAY_IW-1:0]   hit_way, vict_way;

  logic                hit_q, vict_valid_q;
  logic [WAY_IW-1:0]   hit_way_q, vict_way_q, way_sel;

  logic [STAMP_WIDTH-1:0] clk_q, clk_d, stamp_new;
  logic [CNT_W-1:0]       hits_q, hits_d, misses_q, misses_d, evicts_q, evicts_d;
  logic [OC_W-1:0]        outcome;

  logic out_valid_q;
  out_t out_q;

  // clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o = '{clr_done: (clr_cnt_q == SET_IW'(ROWS - 1)),
                   out_free: (~out_valid_q | out_ready_i)};

  // address split into set and tag
  always_comb begin
    sb_eff    = ({1'b0, cfg_i.set_bits} > (SB_W + 1)'(MAX_SET_BITS)) ?
                (SB_W + 1)'(MAX_SET_BITS) : {1'b0, cfg_i.set_bits};
    blk_shift = in_address_i >> cfg_i.block_bits;
    set_mask  = ~({ADDR_W{1'b1}} << sb_eff);
    set_full  = blk_shift & set_mask;
    set_lk    = set_full[SET_IW-1:0];
    tag_amt   = 7'(sb_eff) + 7'(cfg_i.block_bits);
    tag_lk    = tag_amt[6] ? '0 : (in_address_i >> tag_amt[5:0]);
  end

  assign rd_en   = cmd_i.lookup | cmd_i.reread;
  assign rd_addr = cmd_i.lookup ? set_lk : set_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      set_q <= set_lk;
      tag_q <= tag_lk;
    end
  end

  // memory read port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_valid_q <= mem_valid[rd_addr];
      rd_tag_q   <= mem_tag[rd_addr];
      rd_stamp_q <= mem_stamp[rd_addr];
    end
  end

  // memory write port: clearing pass or row update
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem_valid[clr_cnt_q] <= '0;
      mem_tag[clr_cnt_q]   <= '0;
      mem_stamp[clr_cnt_q] <= '0;
    end else if (cmd_i.update) begin
      mem_valid[set_q] <= wr_valid;
      mem_tag[set_q]   <= wr_tag;
      mem_stamp[set_q] <= wr_stamp;
    end
  end

  // ways taking part
  always_comb begin
    ways_raw = {1'b0, cfg_i.ways_in_use};
    if (ways_raw == '0) begin
      ways_eff = (WAYS_W + 1)'(1);
    end else if (ways_raw > (WAYS_W + 1)'(MAX_WAYS)) begin
      ways_eff = (WAYS_W + 1)'(MAX_WAYS);
    end else begin
      ways_eff = ways_raw;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = ((WAYS_W + 1)'(w) < ways_eff);
    end
  end

  // parallel tag compare, first matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w] = in_use[w] & rd_valid_q[w] & (rd_tag_q[w] == tag_q);
    end
    hit_any = |match;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_IW'(w);
    end
  end

  // victim: first way with the smallest stamp, all pairs compared at once
  always_comb begin
    vict_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      is_min[w] = in_use[w];
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (v < w && in_use[v]) begin
          is_min[w] = is_min[w] & (rd_stamp_q[w] < rd_stamp_q[v]);
        end else if (v > w && in_use[v]) begin
          is_min[w] = is_min[w] & (rd_stamp_q[w] <= rd_stamp_q[v]);
        end
      end
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (is_min[w]) vict_way = WAY_IW'(w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      hit_q        <= hit_any;
      hit_way_q    <= hit_way;
      vict_way_q   <= vict_way;
      vict_valid_q <= rd_valid_q[vict_way];
    end
  end

  // row update, stamp clock and totals
  always_comb begin
    way_sel   = hit_q ? hit_way_q : vict_way_q;
    stamp_new = hit_q ? clk_q : clk_q + 1'b1;
    clk_d     = hit_q ? clk_q + 1'b1 : clk_q + 2'd2;
    wr_valid  = rd_valid_q;
    wr_tag    = rd_tag_q;
    wr_stamp  = rd_stamp_q;
    wr_valid[way_sel] = 1'b1;
    wr_tag[way_sel]   = tag_q;
    wr_stamp[way_sel] = stamp_new;

    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (hit_q) begin
      outcome = OC_HIT;
      if (hits_q != '1) hits_d = hits_q + 1'b1;
    end else begin
      if (misses_q != '1) misses_d = misses_q + 1'b1;
      if (vict_valid_q) begin
        outcome = OC_EVICT;
        if (evicts_q != '1) evicts_d = evicts_q + 1'b1;
      end else begin
        outcome = OC_FILL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q    <= '0;
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (cmd_i.update) begin
      clk_q    <= clk_d;
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_q <= '{outcome: outcome, hit_total: hits_d, miss_total: misses_d,
                 eviction_total: evicts_d, last: cmd_i.last};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/sacl_checker.sv */
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the cache tag store: output hold under stall, one
// access in flight at a time, and consistency of the running totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sacl_checker import sacl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a data access blocks further input while it is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.opcode != OP_FETCH) |=> !in_ready_o)
    else $error("input accepted during an access");

  // hit total never decreases
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o) |->
      out_data_o.hit_total >= $past(out_data_o.hit_total))
    else $error("hit total went down");

  // every eviction is also a miss
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.eviction_total <= out_data_o.miss_total)
    else $error("evictions exceed misses");

  // an eviction outcome is counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome == OC_EVICT) |-> out_data_o.eviction_total != '0)
    else $error("eviction not counted");

endmodule

bind set_associative_cache_lru_model_core sacl_checker u_checker (.*);
